[sv/assert_macros.svh]
// assertion macros used by the port checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle, masked during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle, masked during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked during reset as well
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/uvs_pkg.sv]
// shared types, constants and rounding helpers for the uv sphere generator
// no dependencies
package uvs_pkg;

    localparam int CNT_W   = 9;
    localparam int IDX_W   = 17;
    localparam int QUO_W   = 17;
    localparam int CFG_A_W = 2;
    localparam int CFG_D_W = 16;
    localparam int DIV_STEPS = QUO_W;

    localparam logic [CFG_A_W-1:0] REG_RADIUS  = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_SECTORS = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_STACKS  = 2'd2;

    localparam logic [15:0] RADIUS_RST  = 16'd256;
    localparam logic [CNT_W-1:0] SECTORS_RST = 9'd36;
    localparam logic [CNT_W-1:0] STACKS_RST  = 9'd18;

    localparam int MAX_SECTORS_DEF = 256;
    localparam int MAX_STACKS_DEF  = 256;

    // quarter-wave sine coefficients, Q28
    localparam logic [29:0] SIN_C0 = 30'd421657428;
    localparam logic [29:0] SIN_C1 = 30'd173399668;
    localparam logic [29:0] SIN_C2 = 30'd21392319;
    localparam logic [29:0] SIN_C3 = 30'd1214623;

    localparam int SINE_LAT = 6;

    typedef struct packed {
        logic [CNT_W-1:0] rem;
        logic [QUO_W-1:0] num;
    } div_lane_t;

    // divider lanes: 0 = tex_v, 1 = tex_u, 2 = longitude phase
    typedef struct packed {
        div_lane_t [2:0]  lane;
        logic [CNT_W-1:0] sc;
        logic [CNT_W-1:0] st;
        logic [IDX_W-1:0] k1;
        logic [IDX_W-1:0] k2;
        logic             up;
        logic             lo;
    } cell_data_t;

    typedef struct packed {
        logic [15:0]      tu;
        logic [15:0]      tv;
        logic [IDX_W-1:0] k1;
        logic [IDX_W-1:0] k2;
        logic             up;
        logic             lo;
    } side_t;

    // signed shift right, rounding half away from zero
    function automatic logic signed [47:0] round_shift(input logic signed [47:0] v,
                                                       input int sh);
        logic [47:0] mag;
        logic [47:0] half;
        half = 48'(1) << (sh - 1);
        mag  = v[47] ? 48'(-v) : 48'(v);
        mag  = (mag + half) >> sh;
        return v[47] ? -signed'(mag) : signed'(mag);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        if (v > 48'sd32767) begin
            return 16'sh7fff;
        end else if (v < -48'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

endpackage

[sv/uv_sphere_vertex_generator_top.sv]
// one grid point per cycle sustained while the output is not stalled, through the pipeline
// of input stage, 17 division cells, six-stage sine units, two product stages and output
// the whole pipeline advances whenever the output register is empty or being taken
// synchronous active-low reset clears valid flags and restores register defaults
// depends on uvs_pkg, uvs_div_cell, uvs_sine
module uv_sphere_vertex_generator_top #(
    parameter int MAX_SECTORS = uvs_pkg::MAX_SECTORS_DEF,
    parameter int MAX_STACKS  = uvs_pkg::MAX_STACKS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [uvs_pkg::CFG_A_W-1:0]  cfg_addr,
    input  logic [uvs_pkg::CFG_D_W-1:0]  cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [uvs_pkg::CNT_W-1:0]    s_stack_pos,
    input  logic [uvs_pkg::CNT_W-1:0]    s_sector_pos,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [15:0]           m_pos_x,
    output logic signed [15:0]           m_pos_y,
    output logic signed [15:0]           m_pos_z,
    output logic signed [15:0]           m_normal_x,
    output logic signed [15:0]           m_normal_y,
    output logic signed [15:0]           m_normal_z,
    output logic [15:0]                  m_tex_u,
    output logic [15:0]                  m_tex_v,
    output logic [uvs_pkg::IDX_W-1:0]    m_upper_vertex,
    output logic [uvs_pkg::IDX_W-1:0]    m_lower_vertex,
    output logic                         m_upper_tri_valid,
    output logic                         m_lower_tri_valid
);
    import uvs_pkg::*;

    logic [15:0]      radius_reg;
    logic [CNT_W-1:0] sectors_reg, stacks_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg  <= RADIUS_RST;
            sectors_reg <= SECTORS_RST;
            stacks_reg  <= STACKS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_RADIUS:  radius_reg  <= cfg_wdata;
                REG_SECTORS: sectors_reg <= cfg_wdata[CNT_W-1:0];
                REG_STACKS:  stacks_reg  <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    logic adv;
    logic m_valid_reg;
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // input stage: clamp, numerators, vertex indices
    logic [CNT_W-1:0] sc, st, ic, jc;
    logic [24:0]      n_tv, n_tu, n_lon;
    logic [18:0]      k1_full;
    cell_data_t       in_data;
    logic             in_valid_reg;
    cell_data_t       in_data_reg;

    always_comb begin
        if (sectors_reg == '0) begin
            sc = CNT_W'(1);
        end else if (int'(sectors_reg) > MAX_SECTORS) begin
            sc = CNT_W'(MAX_SECTORS);
        end else begin
            sc = sectors_reg;
        end
        if (stacks_reg == '0) begin
            st = CNT_W'(1);
        end else if (int'(stacks_reg) > MAX_STACKS) begin
            st = CNT_W'(MAX_STACKS);
        end else begin
            st = stacks_reg;
        end
        ic = (s_stack_pos > st) ? st : s_stack_pos;
        jc = (s_sector_pos > sc) ? sc : s_sector_pos;

        n_tv  = {1'b0, ic, 15'd0} + 25'(st >> 1);
        n_tu  = {1'b0, jc, 15'd0} + 25'(sc >> 1);
        n_lon = {jc, 16'd0} + 25'(sc >> 1);
        k1_full = 19'(ic) * 19'({1'b0, sc} + 10'd1) + 19'(jc);

        // quotient fits 17 bits, so the top bits start as the partial remainder
        in_data.lane[0].rem = {1'b0, n_tv[24:17]};
        in_data.lane[0].num = n_tv[16:0];
        in_data.lane[1].rem = {1'b0, n_tu[24:17]};
        in_data.lane[1].num = n_tu[16:0];
        in_data.lane[2].rem = {1'b0, n_lon[24:17]};
        in_data.lane[2].num = n_lon[16:0];
        in_data.sc = sc;
        in_data.st = st;
        in_data.k1 = k1_full[IDX_W-1:0];
        in_data.k2 = IDX_W'(k1_full + 19'(sc) + 19'd1);
        in_data.up = (ic != '0) && (ic < st) && (jc < sc);
        in_data.lo = ({1'b0, ic} + 10'd1 != {1'b0, st}) && (ic < st) && (jc < sc);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (adv) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_data_reg <= in_data;
        end
    end

    // division chain
    logic       cv [0:DIV_STEPS];
    cell_data_t cd [0:DIV_STEPS];
    assign cv[0] = in_valid_reg;
    assign cd[0] = in_data_reg;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        uvs_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .valid_in  (cv[g]),
            .data_in   (cd[g]),
            .valid_out (cv[g+1]),
            .data_out  (cd[g+1])
        );
    end

    cell_data_t  dq;
    logic [15:0] lat, lon;
    side_t       side_in;
    assign dq  = cd[DIV_STEPS];
    assign lat = 16'd16384 - dq.lane[0].num[15:0];
    assign lon = dq.lane[2].num[15:0];

    assign side_in.tu = dq.lane[1].num[15:0];
    assign side_in.tv = dq.lane[0].num[15:0];
    assign side_in.k1 = dq.k1;
    assign side_in.k2 = dq.k2;
    assign side_in.up = dq.up;
    assign side_in.lo = dq.lo;

    logic signed [15:0] sl, cl, so, co;

    uvs_sine u_sin_lat (.aclk(aclk), .en(adv), .phase(lat), .sine(sl));
    uvs_sine u_cos_lat (.aclk(aclk), .en(adv), .phase(lat + 16'd16384), .sine(cl));
    uvs_sine u_sin_lon (.aclk(aclk), .en(adv), .phase(lon), .sine(so));
    uvs_sine u_cos_lon (.aclk(aclk), .en(adv), .phase(lon + 16'd16384), .sine(co));

    logic  tv_reg [0:SINE_LAT-1];
    side_t ts_reg [0:SINE_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < SINE_LAT; s++) begin
                tv_reg[s] <= 1'b0;
            end
        end else if (adv) begin
            tv_reg[0] <= cv[DIV_STEPS];
            for (int s = 1; s < SINE_LAT; s++) begin
                tv_reg[s] <= tv_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ts_reg[0] <= side_in;
            for (int s = 1; s < SINE_LAT; s++) begin
                ts_reg[s] <= ts_reg[s-1];
            end
        end
    end

    // product stage: q28 direction components
    logic               pv_reg;
    side_t              ps_reg;
    logic signed [29:0] pxq_reg, pyq_reg;
    logic signed [15:0] psl_reg;

    // radius stage
    logic               rv_reg;
    side_t              rs_reg;
    logic signed [46:0] rx_reg, ry_reg;
    logic signed [32:0] rz_reg;
    logic signed [15:0] nx_reg, ny_reg, nz_reg;

    logic signed [47:0] nx_full, ny_full, px_full, py_full, pz_full;
    assign nx_full = round_shift(48'(pxq_reg), 14);
    assign ny_full = round_shift(48'(pyq_reg), 14);
    assign px_full = round_shift(48'(rx_reg), 28);
    assign py_full = round_shift(48'(ry_reg), 28);
    assign pz_full = round_shift(48'(rz_reg), 14);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg      <= 1'b0;
            rv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            pv_reg      <= tv_reg[SINE_LAT-1];
            rv_reg      <= pv_reg;
            m_valid_reg <= rv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ps_reg  <= ts_reg[SINE_LAT-1];
            pxq_reg <= cl * co;
            pyq_reg <= cl * so;
            psl_reg <= sl;

            rs_reg <= ps_reg;
            rx_reg <= $signed({1'b0, radius_reg}) * pxq_reg;
            ry_reg <= $signed({1'b0, radius_reg}) * pyq_reg;
            rz_reg <= $signed({1'b0, radius_reg}) * psl_reg;
            nx_reg <= nx_full[15:0];
            ny_reg <= ny_full[15:0];
            nz_reg <= psl_reg;

            m_pos_x           <= sat16(px_full);
            m_pos_y           <= sat16(py_full);
            m_pos_z           <= sat16(pz_full);
            m_normal_x        <= nx_reg;
            m_normal_y        <= ny_reg;
            m_normal_z        <= nz_reg;
            m_tex_u           <= rs_reg.tu;
            m_tex_v           <= rs_reg.tv;
            m_upper_vertex    <= rs_reg.k1;
            m_lower_vertex    <= rs_reg.k2;
            m_upper_tri_valid <= rs_reg.up;
            m_lower_tri_valid <= rs_reg.lo;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

[sv/uvs_div_cell.sv]
// one restoring-division cell: one quotient bit for each of three lanes
// depends on uvs_pkg
module uvs_div_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               valid_in,
    input  uvs_pkg::cell_data_t data_in,
    output logic               valid_out,
    output uvs_pkg::cell_data_t data_out
);
    import uvs_pkg::*;

    cell_data_t data_next;
    logic       valid_reg;
    cell_data_t data_reg;

    always_comb begin
        logic [CNT_W:0]   rem2;
        logic [CNT_W:0]   dvs;
        logic             ge;
        data_next = data_in;
        for (int n = 0; n < 3; n++) begin
            dvs  = (n == 0) ? {1'b0, data_in.st} : {1'b0, data_in.sc};
            rem2 = {data_in.lane[n].rem, data_in.lane[n].num[QUO_W-1]};
            ge   = (rem2 >= dvs);
            data_next.lane[n].rem = ge ? CNT_W'(rem2 - dvs) : CNT_W'(rem2);
            data_next.lane[n].num = {data_in.lane[n].num[QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

[sv/uvs_sine.sv]
// pipelined sine of a 16-bit turn phase, Q14 result, six register stages
// depends on uvs_pkg
module uvs_sine (
    input  logic               aclk,
    input  logic               en,
    input  logic [15:0]        phase,
    output logic signed [15:0] sine
);
    import uvs_pkg::*;

    logic [14:0] z_reg [0:4];
    logic        neg_reg [0:4];
    logic [28:0] z2_reg [1:3];
    logic [29:0] p3_reg, p4_reg, p5_reg;
    logic signed [15:0] sine_reg;

    logic [58:0] m3, m4, m5;
    logic [44:0] m6;
    logic [15:0] mag6;

    assign m3   = 59'(z2_reg[1]) * 59'(SIN_C3);
    assign m4   = 59'(z2_reg[2]) * 59'(p3_reg);
    assign m5   = 59'(z2_reg[3]) * 59'(p4_reg);
    assign m6   = 45'(z_reg[4]) * 45'(p5_reg) + (45'(1) << 27);
    assign mag6 = 16'(m6 >> 28);

    always_ff @(posedge aclk) begin
        if (en) begin
            // fold the phase into a quarter wave
            z_reg[0]   <= phase[14] ? 15'(15'd16384 - {1'b0, phase[13:0]})
                                    : {1'b0, phase[13:0]};
            neg_reg[0] <= phase[15];
            for (int s = 1; s < 5; s++) begin
                z_reg[s]   <= z_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
            end
            z2_reg[1] <= 29'(z_reg[0]) * 29'(z_reg[0]);
            for (int s = 2; s < 4; s++) begin
                z2_reg[s] <= z2_reg[s-1];
            end
            p3_reg   <= SIN_C2 - 30'(m3 >> 28);
            p4_reg   <= SIN_C1 - 30'(m4 >> 28);
            p5_reg   <= SIN_C0 - 30'(m5 >> 28);
            sine_reg <= neg_reg[4] ? -signed'(mag6) : signed'(mag6);
        end
    end

    assign sine = sine_reg;

endmodule

[sv/uvs_checker.sv]
// port-level checks for the uv sphere generator, bound to the top level
// depends on assert_macros.svh and uv_sphere_vertex_generator_top
`include "assert_macros.svh"

module uvs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_pos_x,
    input logic [15:0] m_tex_u,
    input logic [15:0] m_tex_v,
    input logic        m_upper_tri_valid,
    input logic        m_lower_tri_valid
);

    // a stalled result holds
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_pos_x))

    // reset empties the output
    `ASSERT_NEXT_ALWAYS(a_reset, aclk, !aresetn, !m_valid)

    // an upper triangle never sits on the north pole row
    `ASSERT_IMPLY(a_upper, aclk, aresetn, m_valid && m_upper_tri_valid, m_tex_v != 16'd0)

    // a quad never starts on the seam column
    `ASSERT_IMPLY(a_lower, aclk, aresetn, m_valid && m_lower_tri_valid, m_tex_u < 16'h8000)

endmodule

bind uv_sphere_vertex_generator_top uvs_checker u_uvs_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_pos_x           (m_pos_x),
    .m_tex_u           (m_tex_u),
    .m_tex_v           (m_tex_v),
    .m_upper_tri_valid (m_upper_tri_valid),
    .m_lower_tri_valid (m_lower_tri_valid)
);

[dv/uvs_vertex_checker.sv]
// checker for the uv sphere generator: tracks register writes, predicts each grid point
// and compares the result channel field by field in order
// depends on uvs_pkg
module uvs_vertex_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [uvs_pkg::CFG_A_W-1:0]  cfg_addr,
    input  logic [uvs_pkg::CFG_D_W-1:0]  cfg_wdata,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [uvs_pkg::CNT_W-1:0]    s_stack_pos,
    input  logic [uvs_pkg::CNT_W-1:0]    s_sector_pos,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic signed [15:0]           m_pos_x,
    input  logic signed [15:0]           m_pos_y,
    input  logic signed [15:0]           m_pos_z,
    input  logic signed [15:0]           m_normal_x,
    input  logic signed [15:0]           m_normal_y,
    input  logic signed [15:0]           m_normal_z,
    input  logic [15:0]                  m_tex_u,
    input  logic [15:0]                  m_tex_v,
    input  logic [uvs_pkg::IDX_W-1:0]    m_upper_vertex,
    input  logic [uvs_pkg::IDX_W-1:0]    m_lower_vertex,
    input  logic                         m_upper_tri_valid,
    input  logic                         m_lower_tri_valid,
    output int                           errors,
    output int                           pending,
    output int                           vertices_seen
);
    import uvs_pkg::*;

    localparam longint unsigned SINE_K0 = 421657428;
    localparam longint unsigned SINE_K1 = 173399668;
    localparam longint unsigned SINE_K2 = 21392319;
    localparam longint unsigned SINE_K3 = 1214623;
    localparam longint unsigned GRID_MAX = 256;

    typedef struct {
        logic signed [15:0] px, py, pz, nx, ny, nz;
        logic [15:0]        tu, tv;
        logic [IDX_W-1:0]   k1, k2;
        logic               up, lo;
    } vertex_t;

    logic [15:0]      radius_q;
    logic [CNT_W-1:0] sectors_q;
    logic [CNT_W-1:0] stacks_q;
    vertex_t          vertex_queue[$];
    vertex_t          want, seen;

    function automatic longint quarter_wave(longint unsigned z);
        longint unsigned z2, p;
        z2 = z * z;
        p  = SINE_K3;
        p  = SINE_K2 - ((z2 * p) >> 28);
        p  = SINE_K1 - ((z2 * p) >> 28);
        p  = SINE_K0 - ((z2 * p) >> 28);
        return longint'((z * p + (64'd1 << 27)) >> 28);
    endfunction

    function automatic longint turn_sine(longint unsigned ph);
        longint unsigned quad, rem;
        longint v;
        quad = (ph >> 14) & 3;
        rem  = ph & 16383;
        v = quad[0] ? quarter_wave(16384 - rem) : quarter_wave(rem);
        return quad[1] ? -v : v;
    endfunction

    function automatic longint round_away(longint v, int sh);
        longint half;
        half = 64'sd1 <<< (sh - 1);
        if (v < 0) begin
            return -((-v + half) >>> sh);
        end
        return (v + half) >>> sh;
    endfunction

    function automatic logic signed [15:0] clip16(longint v);
        if (v > 32767) begin
            return 16'sh7fff;
        end else if (v < -32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    function automatic vertex_t grid_vertex(logic [CNT_W-1:0] row, logic [CNT_W-1:0] col);
        vertex_t r;
        longint unsigned sc, st, i, j, tv, tu, lat, lon, k1;
        longint sl, cl, so, co, pxq, pyq, rad;
        sc = (sectors_q == 0) ? 1 : (sectors_q > GRID_MAX) ? GRID_MAX : sectors_q;
        st = (stacks_q == 0) ? 1 : (stacks_q > GRID_MAX) ? GRID_MAX : stacks_q;
        i = (row > st) ? st : row;
        j = (col > sc) ? sc : col;
        tv  = (i * 32768 + st / 2) / st;
        tu  = (j * 32768 + sc / 2) / sc;
        lat = (16384 - tv) & 16'hffff;
        lon = ((j * 65536 + sc / 2) / sc) & 16'hffff;
        sl  = turn_sine(lat);
        cl  = turn_sine((lat + 16384) & 16'hffff);
        so  = turn_sine(lon);
        co  = turn_sine((lon + 16384) & 16'hffff);
        pxq = cl * co;
        pyq = cl * so;
        rad = longint'(radius_q);
        r.px = clip16(round_away(rad * pxq, 28));
        r.py = clip16(round_away(rad * pyq, 28));
        r.pz = clip16(round_away(rad * sl, 14));
        r.nx = 16'(round_away(pxq, 14));
        r.ny = 16'(round_away(pyq, 14));
        r.nz = 16'(sl);
        r.tu = 16'(tu);
        r.tv = 16'(tv);
        k1   = i * (sc + 1) + j;
        r.k1 = IDX_W'(k1);
        r.k2 = IDX_W'(k1 + sc + 1);
        r.up = (i != 0 && i < st && j < sc);
        r.lo = (i + 1 != st && i < st && j < sc);
        return r;
    endfunction

    function automatic void match_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            radius_q  <= RADIUS_RST;
            sectors_q <= SECTORS_RST;
            stacks_q  <= STACKS_RST;
            vertex_queue.delete();
            errors = 0;
            vertices_seen <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_RADIUS: begin
                        radius_q <= cfg_wdata;
                    end
                    REG_SECTORS: begin
                        sectors_q <= cfg_wdata[CNT_W-1:0];
                    end
                    REG_STACKS: begin
                        stacks_q <= cfg_wdata[CNT_W-1:0];
                    end
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                vertex_queue.insert(vertex_queue.size(),
                                    grid_vertex(s_stack_pos, s_sector_pos));
            end
            if (m_valid && m_ready) begin
                vertices_seen <= vertices_seen + 1;
                seen = '{m_pos_x, m_pos_y, m_pos_z, m_normal_x, m_normal_y, m_normal_z,
                         m_tex_u, m_tex_v, m_upper_vertex, m_lower_vertex,
                         m_upper_tri_valid, m_lower_tri_valid};
                if (vertex_queue.size() == 0) begin
                    errors++;
                    $display("%0t: result transfer with nothing expected", $time);
                end else begin
                    want = vertex_queue.pop_front();
                    match_field("pos_x", want.px, seen.px);
                    match_field("pos_y", want.py, seen.py);
                    match_field("pos_z", want.pz, seen.pz);
                    match_field("normal_x", want.nx, seen.nx);
                    match_field("normal_y", want.ny, seen.ny);
                    match_field("normal_z", want.nz, seen.nz);
                    match_field("tex_u", want.tu, seen.tu);
                    match_field("tex_v", want.tv, seen.tv);
                    match_field("upper_vertex", want.k1, seen.k1);
                    match_field("lower_vertex", want.k2, seen.k2);
                    match_field("upper_tri_valid", want.up, seen.up);
                    match_field("lower_tri_valid", want.lo, seen.lo);
                end
            end
        end
        pending = vertex_queue.size();
    end

endmodule

[dv/uv_sphere_vertex_generator_top_tb.sv]
// testbench top for the uv sphere generator: drives grid points and register settings,
// stalls the result side, and reports the verdict
// depends on uvs_pkg, uv_sphere_vertex_generator_top, uvs_vertex_checker
module uv_sphere_vertex_generator_top_tb;
    import uvs_pkg::*;

    localparam logic [CFG_A_W-1:0] REG_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASES = 7;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_A_W-1:0]     cfg_addr = '0;
    logic [CFG_D_W-1:0]     cfg_wdata = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [CNT_W-1:0]       s_stack_pos = '0;
    logic [CNT_W-1:0]       s_sector_pos = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic signed [15:0]     m_pos_x, m_pos_y, m_pos_z;
    logic signed [15:0]     m_normal_x, m_normal_y, m_normal_z;
    logic [15:0]            m_tex_u, m_tex_v;
    logic [IDX_W-1:0]       m_upper_vertex, m_lower_vertex;
    logic                   m_upper_tri_valid, m_lower_tri_valid;

    logic s_fire = 1'b0;
    int   errors, pending, vertices_seen;
    int   quiet_cycles = 0;
    int   points_sent = 0;
    int   stall_left = 0;
    int   stall_mode = 0;

    // radius, sectors, stacks per phase; phase 0 keeps the reset values
    int radius_set[PHASES]  = '{256, 65535, 1, 0, 16'h1234, 384, 700};
    int sectors_set[PHASES] = '{36, 256, 1, 0, 511, 7, 3};
    int stacks_set[PHASES]  = '{18, 256, 1, 0, 300, 5, 2};

    uv_sphere_vertex_generator_top u_dut (.*);

    uvs_vertex_checker u_checker (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        s_fire <= s_valid && s_ready;
    end

    // result side stalls in stretches: always ready, coin flip, or mostly stalled
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(5, 60);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles == QUIET_LIMIT) begin
                $display("timeout with %0d results outstanding", pending);
                $display("FAILED: results differ");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic push_point(int row, int col);
        s_valid      <= 1'b1;
        s_stack_pos  <= CNT_W'(row);
        s_sector_pos <= CNT_W'(col);
        @(negedge aclk);
        while (!s_fire) @(negedge aclk);
        points_sent++;
    endtask

    task automatic hold_off(int n);
        s_valid <= 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_A_W-1:0] idx, int value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_D_W'(value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        int rows, cols, burst;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                drain_results();
                write_reg(REG_RADIUS, radius_set[ph]);
                write_reg(REG_SECTORS, sectors_set[ph]);
                write_reg(REG_STACKS, stacks_set[ph]);
                if (ph == 2) begin
                    write_reg(REG_UNUSED, 16'hffff);
                end
            end
            rows = (stacks_set[ph] == 0) ? 1 : (stacks_set[ph] > 256) ? 256 : stacks_set[ph];
            cols = (sectors_set[ph] == 0) ? 1 : (sectors_set[ph] > 256) ? 256 : sectors_set[ph];
            // poles, seams, last row, and indices past the grid
            push_point(0, 0);
            push_point(rows, cols);
            push_point(rows - 1, cols - 1);
            push_point(511, 511);
            push_point(0, 511);
            push_point(511, 0);
            push_point(rows / 2, cols / 2);
            push_point(rows - 1, 0);
            push_point(1, cols);
            for (int n = 0; n < 170; ) begin
                burst = $urandom_range(1, 16);
                for (int b = 0; b < burst && n < 170; b++, n++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        push_point($urandom_range(0, 511), $urandom_range(0, 511));
                    end else begin
                        push_point($urandom_range(0, rows), $urandom_range(0, cols));
                    end
                end
                if (ph == 1 && n >= 60 && n < 76) begin
                    drain_results();
                end else if ($urandom_range(0, 3) != 0) begin
                    hold_off($urandom_range(1, 8));
                end
            end
        end
        drain_results();
        $display("sent %0d grid points over %0d register settings, %0d vertices checked",
                 points_sent, PHASES, vertices_seen);
        if (errors == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
